// File: rtl/core/escaped_serial_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escaped serial frame receiver.
// Each macro takes a label, an antecedent, a consequent and a message.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_SERIAL_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/esfr_pkg.sv
// ----------------------------------------------------------------------------
// esfr_pkg
// Types and constants shared by the escaped serial frame receiver files.
// ----------------------------------------------------------------------------
`default_nettype none

package esfr_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_FOR_7D  = 8'h5D;
  localparam logic [7:0] ESC_FOR_7E  = 8'h5E;
  localparam logic [7:0] MIN_LEN     = 8'd2;
  localparam logic [7:0] CSUM_BYTES  = 8'd2;

  localparam logic [7:0] SLOT_ID_RST    = 8'hFF;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd100;

  // Register index, taken from paddr bit 2.
  localparam logic REG_SLOT_ID    = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEAD = 2'd1,
    MODE_LEN  = 2'd2,
    MODE_BODY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DATA = 3'd0,
    KIND_GOOD = 3'd1,
    KIND_CSUM = 3'd2,
    KIND_LEN  = 3'd3,
    KIND_DROP = 3'd4
  } kind_t;

endpackage

`default_nettype wire

// File: rtl/core/escaped_serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_serial_frame_receiver
// Byte-stuffed serial frame deframer with additive and XOR checksums.
// ----------------------------------------------------------------------------
// The block takes one raw byte per transaction and accepts a new byte every
// clock cycle while its result path is not stalled. A byte first lands in an
// input register; when the output register is free, the frame state machine
// and running checksums are updated and any result is written to the output
// register. The one-cycle rate is set by the state update loop through the
// mode, escape, byte count and checksum registers. While a result waits in
// the output register, the input register holds at most one more byte and
// in_ready stays low once it holds one, until the result is taken. Payload
// bytes stream out as kind 0; every frame that passes the header ends with a
// status (good, checksum error, length error or dropped). Write slot_id at
// address 0 and max_length at address 4 only while no frame is in flight.
`default_nettype none

module escaped_serial_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data,
  output logic [7:0]       out_payload_len,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import esfr_pkg::*;

  // Configuration registers
  logic [7:0] slot_id_r;
  logic [7:0] max_length_r;

  // Input register
  logic       in_vld_r;
  logic [7:0] byte_r;

  // Frame state
  mode_t      mode_r, mode_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] flen_r, flen_nxt;
  logic [7:0] sadd_r, sadd_nxt;
  logic [7:0] sxor_r, sxor_nxt;
  logic       aok_r, aok_nxt;

  // Output register
  logic       out_vld_r;
  kind_t      kind_r;
  logic [7:0] data_r;
  logic [7:0] plen_r;

  // Result of the byte in the input register
  logic       res_vld;
  kind_t      res_kind;
  logic [7:0] res_data;
  logic [7:0] res_plen;

  // Body byte decode
  logic       is_hdr;
  logic       esc_bad;
  logic       esc_start;
  logic [7:0] ub;
  logic       adv;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_id_r    <= SLOT_ID_RST;
      max_length_r <= MAX_LENGTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SLOT_ID:    slot_id_r    <= pwdata[7:0];
        REG_MAX_LENGTH: max_length_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOT_ID:    prdata = {24'd0, slot_id_r};
      REG_MAX_LENGTH: prdata = {24'd0, max_length_r};
      default:        prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the held byte advances when the output register is free.
  // --------------------------------------------------------------------------
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Body byte decode. A pending escape turns the follower into its literal
  // value; an unknown follower kills the frame.
  // --------------------------------------------------------------------------
  always_comb begin
    is_hdr    = (byte_r == HDR_BYTE);
    esc_bad   = 1'b0;
    esc_start = 1'b0;
    ub        = byte_r;
    if (esc_r) begin
      if (byte_r == ESC_FOR_7D) begin
        ub = ESC_BYTE;
      end else if (byte_r == ESC_FOR_7E) begin
        ub = HDR_BYTE;
      end else begin
        esc_bad = 1'b1;
      end
    end else if (byte_r == ESC_BYTE) begin
      esc_start = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    left_nxt = left_r;
    flen_nxt = flen_r;
    sadd_nxt = sadd_r;
    sxor_nxt = sxor_r;
    aok_nxt  = aok_r;
    unique case (mode_r)
      MODE_IDLE: begin
        if (is_hdr) begin
          mode_nxt = MODE_HEAD;
        end
      end
      MODE_HEAD: begin
        if (byte_r != slot_id_r) begin
          mode_nxt = MODE_IDLE;
        end else begin
          sadd_nxt = byte_r;
          sxor_nxt = byte_r;
          mode_nxt = MODE_LEN;
        end
      end
      MODE_LEN: begin
        if (byte_r < MIN_LEN || byte_r > max_length_r) begin
          mode_nxt = MODE_IDLE;
          sadd_nxt = 8'd0;
          sxor_nxt = 8'd0;
        end else begin
          flen_nxt = byte_r;
          left_nxt = byte_r;
          sadd_nxt = sadd_r + byte_r;
          sxor_nxt = sxor_r ^ byte_r;
          aok_nxt  = 1'b0;
          esc_nxt  = 1'b0;
          mode_nxt = MODE_BODY;
        end
      end
      MODE_BODY: begin
        if (is_hdr || esc_bad) begin
          // A bare header restarts the frame at once.
          mode_nxt = is_hdr ? MODE_HEAD : MODE_IDLE;
          esc_nxt  = 1'b0;
          left_nxt = 8'd0;
          flen_nxt = 8'd0;
          sadd_nxt = 8'd0;
          sxor_nxt = 8'd0;
          aok_nxt  = 1'b0;
        end else if (esc_start) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          if (left_r > CSUM_BYTES) begin
            left_nxt = left_r - 8'd1;
            sadd_nxt = sadd_r + ub;
            sxor_nxt = sxor_r ^ ub;
          end else if (left_r == CSUM_BYTES) begin
            left_nxt = 8'd1;
            aok_nxt  = (ub == sadd_r);
          end else begin
            mode_nxt = MODE_IDLE;
            left_nxt = 8'd0;
            flen_nxt = 8'd0;
            sadd_nxt = 8'd0;
            sxor_nxt = 8'd0;
            aok_nxt  = 1'b0;
          end
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    res_vld  = 1'b0;
    res_kind = KIND_DATA;
    res_data = 8'd0;
    res_plen = 8'd0;
    unique case (mode_r)
      MODE_IDLE: ;
      MODE_HEAD: begin
        if (byte_r != slot_id_r) begin
          res_vld  = 1'b1;
          res_kind = KIND_DROP;
        end
      end
      MODE_LEN: begin
        if (byte_r < MIN_LEN || byte_r > max_length_r) begin
          res_vld  = 1'b1;
          res_kind = KIND_LEN;
        end
      end
      MODE_BODY: begin
        if (is_hdr || esc_bad) begin
          res_vld  = 1'b1;
          res_kind = KIND_DROP;
        end else if (!esc_start) begin
          if (left_r > CSUM_BYTES) begin
            res_vld  = 1'b1;
            res_kind = KIND_DATA;
            res_data = ub;
          end else if (left_r != CSUM_BYTES) begin
            res_vld = 1'b1;
            if (aok_r && (ub == sxor_r)) begin
              res_kind = KIND_GOOD;
              res_plen = flen_r - CSUM_BYTES;
            end else begin
              res_kind = KIND_CSUM;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      left_r <= 8'd0;
      flen_r <= 8'd0;
      sadd_r <= 8'd0;
      sxor_r <= 8'd0;
      aok_r  <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      left_r <= left_nxt;
      flen_r <= flen_nxt;
      sadd_r <= sadd_nxt;
      sxor_r <= sxor_nxt;
      aok_r  <= aok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= adv && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      kind_r <= res_kind;
      data_r <= res_data;
      plen_r <= res_plen;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_kind        = kind_r;
  assign out_data        = data_r;
  assign out_payload_len = plen_r;

endmodule

`default_nettype wire

// File: rtl/core/esfr_checker.sv
// ----------------------------------------------------------------------------
// esfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escaped_serial_frame_receiver_assert.svh"

module esfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_data,
  input wire logic [7:0] out_payload_len
);

  import esfr_pkg::*;

  // A stalled result keeps its contents.
  `ESFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data) && $stable(out_payload_len), "stalled result changed")

  // Only payload byte transactions carry data.
  `ESFR_ASSERT_NOW(a_data_zero, out_valid && out_kind != KIND_DATA, out_data == 8'd0, "data set on a status result")

  // Only a good frame carries a payload length.
  `ESFR_ASSERT_NOW(a_len_zero, out_valid && out_kind != KIND_GOOD, out_payload_len == 8'd0, "length set on a result that is not good")

  // Kind codes stop at dropped, and a good frame never reports more than 253 bytes.
  `ESFR_ASSERT_NOW(a_kind_range, out_valid, out_kind <= KIND_DROP && out_payload_len <= 8'd253, "result kind or length out of range")

endmodule

bind escaped_serial_frame_receiver esfr_checker u_esfr_checker (.*);

`default_nettype wire

// File: bench/escaped_serial_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// escaped_serial_frame_receiver_tb
// Drives byte streams of escaped frames into the deframer and checks every
// payload byte and frame status against a cycle-free prediction of the
// receive state machine, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_serial_frame_receiver_tb;
  import esfr_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 10;
  localparam int QUIET_LIMIT   = 500;
  localparam int RANDOM_ITEMS  = 240;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] plen;
  } frame_result_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_XOR,
    FLAW_ESC,
    FLAW_RESTART,
    FLAW_SLOT,
    FLAW_LEN
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data;
  logic [7:0]  out_payload_len;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  escaped_serial_frame_receiver DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data       (out_data),
    .out_payload_len(out_payload_len),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Predicted receiver state and register copies.
  logic [7:0] slot_cfg;
  logic [7:0] max_len_cfg;
  mode_t      rx_state;
  logic       esc_seen;
  logic [7:0] body_left;
  logic [7:0] len_byte;
  logic [7:0] run_sum;
  logic [7:0] run_xor;
  logic       sum_matched;

  frame_result_t expected_results[$];

  int error_count;
  int mismatch_count;
  int quiet_cycles;
  int sent_items;
  int ignored_items;
  int burst_left;
  bit steady;

  logic [15:0] stall_bits = 16'hFFFF;
  logic [4:0]  stall_phase = 5'd0;

  function automatic void clear_frame();
    rx_state    = MODE_IDLE;
    esc_seen    = 1'b0;
    body_left   = 8'h00;
    len_byte    = 8'h00;
    run_sum     = 8'h00;
    run_xor     = 8'h00;
    sum_matched = 1'b0;
  endfunction

  // Advances the predicted receiver by one raw byte; returns 1 when the byte
  // produces a result.
  function automatic bit deframe_byte(input logic [7:0] raw, output frame_result_t res);
    logic [7:0] b;
    bit         produced;
    bit         use_byte;
    b        = raw;
    produced = 1'b0;
    use_byte = 1'b0;
    res      = '{kind: KIND_DATA, data: 8'h00, plen: 8'h00};
    case (rx_state)
      MODE_IDLE: begin
        if (b == HDR_BYTE) begin
          clear_frame();
          rx_state = MODE_HEAD;
        end
      end
      MODE_HEAD: begin
        if (b != slot_cfg) begin
          clear_frame();
          produced = 1'b1;
          res.kind = KIND_DROP;
        end else begin
          run_sum  = b;
          run_xor  = b;
          rx_state = MODE_LEN;
        end
      end
      MODE_LEN: begin
        if (b < MIN_LEN || b > max_len_cfg) begin
          clear_frame();
          produced = 1'b1;
          res.kind = KIND_LEN;
        end else begin
          len_byte    = b;
          body_left   = b;
          run_sum     = run_sum + b;
          run_xor     = run_xor ^ b;
          sum_matched = 1'b0;
          esc_seen    = 1'b0;
          rx_state    = MODE_BODY;
        end
      end
      default: begin
        if (b == HDR_BYTE) begin
          // A bare header abandons the frame, even with an escape pending.
          clear_frame();
          rx_state = MODE_HEAD;
          produced = 1'b1;
          res.kind = KIND_DROP;
        end else if (esc_seen) begin
          esc_seen = 1'b0;
          if (b == ESC_FOR_7D) begin
            b        = ESC_BYTE;
            use_byte = 1'b1;
          end else if (b == ESC_FOR_7E) begin
            b        = HDR_BYTE;
            use_byte = 1'b1;
          end else begin
            clear_frame();
            produced = 1'b1;
            res.kind = KIND_DROP;
          end
        end else if (b == ESC_BYTE) begin
          esc_seen = 1'b1;
        end else begin
          use_byte = 1'b1;
        end
        if (use_byte) begin
          if (body_left > CSUM_BYTES) begin
            body_left = body_left - 8'd1;
            run_sum   = run_sum + b;
            run_xor   = run_xor ^ b;
            produced  = 1'b1;
            res.data  = b;
          end else if (body_left == CSUM_BYTES) begin
            body_left   = 8'd1;
            sum_matched = (b == run_sum);
          end else begin
            produced = 1'b1;
            if (sum_matched && b == run_xor) begin
              res.kind = KIND_GOOD;
              res.plen = len_byte - CSUM_BYTES;
            end else begin
              res.kind = KIND_CSUM;
            end
            clear_frame();
          end
        end
      end
    endcase
    return produced;
  endfunction

  // Receiver stall pattern, reloaded each time the phase counter wraps.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 5'd1;
    if (stall_phase == 5'd0) begin
      if ($urandom_range(0, 3) == 0) stall_bits <= 16'hFFFF;
      else stall_bits <= 16'($urandom) | 16'h0001;
    end else begin
      stall_bits <= {stall_bits[0], stall_bits[15:1]};
    end
    out_ready <= stall_bits[0];
  end

  // Result checker.
  always @(posedge clk) begin
    frame_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (mismatch_count < REPORT_LIMIT)
          $display("Unexpected result: kind %0d data %02h len %0d",
                   out_kind, out_data, out_payload_len);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_kind !== exp_res.kind || out_data !== exp_res.data ||
            out_payload_len !== exp_res.plen) begin
          error_count++;
          if (mismatch_count < REPORT_LIMIT)
            $display("Mismatch: expected kind %0d data %02h len %0d, got kind %0d data %02h len %0d",
                     exp_res.kind, exp_res.data, exp_res.plen,
                     out_kind, out_data, out_payload_len);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction completes.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    frame_result_t res;
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    if (deframe_byte(b, res)) expected_results.push_back(res);
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == HDR_BYTE) begin
      send_byte(ESC_BYTE);
      send_byte(ESC_FOR_7E);
    end else if (b == ESC_BYTE) begin
      send_byte(ESC_BYTE);
      send_byte(ESC_FOR_7D);
    end else begin
      send_byte(b);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return HDR_BYTE;
      1: return ESC_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_len();
    if (max_len_cfg == 8'hFF || $urandom_range(0, 1) == 0)
      return 8'($urandom_range(0, 1));
    return 8'($urandom_range(int'(max_len_cfg) + 1, 255));
  endfunction

  function automatic logic [7:0] pick_bad_follower();
    logic [7:0] f;
    f = 8'($urandom);
    while (f == ESC_FOR_7D || f == ESC_FOR_7E || f == HDR_BYTE) f = 8'($urandom);
    return f;
  endfunction

  task automatic send_random_frame(input int plen, input frame_flaw_t flaw);
    logic [7:0] payload[$];
    payload = {};
    for (int i = 0; i < plen; i++) payload.push_back(pick_byte());
    send_frame_bytes(payload, flaw);
  endtask

  // Builds a frame around the payload and sends it, with an optional flaw.
  task automatic send_frame_bytes(input logic [7:0] payload[$], input frame_flaw_t flaw);
    logic [7:0] body[$];
    logic [7:0] csum_add;
    logic [7:0] csum_xor;
    logic [7:0] lenb;
    int cut;
    lenb = 8'(payload.size() + 2);
    if (flaw == FLAW_LEN) lenb = pick_bad_len();
    csum_add = slot_cfg + lenb;
    csum_xor = slot_cfg ^ lenb;
    foreach (payload[i]) begin
      csum_add = csum_add + payload[i];
      csum_xor = csum_xor ^ payload[i];
    end
    if (flaw == FLAW_SUM) csum_add = csum_add ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_XOR) csum_xor = csum_xor ^ 8'($urandom_range(1, 255));
    body = payload;
    body.push_back(csum_add);
    body.push_back(csum_xor);
    cut = $urandom_range(0, body.size() - 1);
    send_byte(HDR_BYTE);
    if (flaw == FLAW_SLOT) send_byte(slot_cfg ^ (8'h01 << $urandom_range(0, 7)));
    else send_byte(slot_cfg);
    send_byte(lenb);
    foreach (body[i]) begin
      if (i == cut && flaw == FLAW_ESC) begin
        send_byte(ESC_BYTE);
        send_byte(pick_bad_follower());
        return;
      end
      if (i == cut && flaw == FLAW_RESTART) begin
        if ($urandom_range(0, 1) == 1) send_byte(ESC_BYTE);
        send_random_frame($urandom_range(0, 6), FLAW_NONE);
        return;
      end
      send_stuffed(body[i]);
    end
  endtask

  // Brings the block back to idle and waits out every pending result.
  task automatic settle_block();
    while (rx_state != MODE_IDLE) begin
      case (rx_state)
        MODE_HEAD: send_byte(~slot_cfg);
        MODE_LEN:  send_byte(8'h00);
        default:   send_byte(HDR_BYTE);
      endcase
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SLOT_ID) slot_cfg = val;
    else max_len_cfg = val;
  endtask

  task automatic set_config(input logic [7:0] slot, input logic [7:0] max_len);
    settle_block();
    write_reg(REG_SLOT_ID, slot);
    write_reg(REG_MAX_LENGTH, max_len);
  endtask

  task automatic test_default_config();
    logic [7:0] payload[$];
    send_byte(8'h00);
    ignored_items++;
    payload = {};
    send_frame_bytes(payload, FLAW_NONE);
    payload = {HDR_BYTE, ESC_BYTE, 8'h00, 8'hFF};
    send_frame_bytes(payload, FLAW_NONE);
    // Length just above the limit, then just below the minimum.
    send_byte(HDR_BYTE);
    send_byte(SLOT_ID_RST);
    send_byte(MAX_LENGTH_RST + 8'd1);
    send_byte(HDR_BYTE);
    send_byte(SLOT_ID_RST);
    send_byte(MIN_LEN - 8'd1);
  endtask

  task automatic test_frame_faults();
    logic [7:0] payload[$];
    // Header while an escape is pending, then the restarted empty frame.
    send_byte(HDR_BYTE);
    send_byte(SLOT_ID_RST);
    send_byte(8'd4);
    send_byte(ESC_BYTE);
    send_byte(HDR_BYTE);
    send_byte(SLOT_ID_RST);
    send_byte(8'd2);
    send_byte(SLOT_ID_RST + 8'd2);
    send_byte(SLOT_ID_RST ^ 8'd2);
    payload = {};
    send_frame_bytes(payload, FLAW_SLOT);
    payload = {8'h11};
    send_frame_bytes(payload, FLAW_ESC);
    payload = {ESC_FOR_7D, ESC_FOR_7E};
    send_frame_bytes(payload, FLAW_SUM);
    payload = {};
    send_frame_bytes(payload, FLAW_XOR);
  endtask

  task automatic test_register_extremes();
    logic [7:0] payload[$];
    payload = {};
    set_config(8'h00, MIN_LEN);
    send_frame_bytes(payload, FLAW_NONE);
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_byte(MIN_LEN + 8'd1);
    // A limit below the minimum rejects every length; the slot equals the header.
    set_config(HDR_BYTE, 8'h00);
    send_frame_bytes(payload, FLAW_NONE);
  endtask

  task automatic test_random_traffic();
    logic [7:0] phase_slot[6];
    logic [7:0] phase_max[6];
    logic [7:0] noise;
    frame_flaw_t flaw;
    int maxp;
    int plen;
    int goal;
    phase_slot = '{8'($urandom), 8'hFF, 8'h00, HDR_BYTE, ESC_BYTE, 8'($urandom)};
    phase_max  = '{8'($urandom_range(12, 255)), 8'hFF, MIN_LEN, 8'd40,
                   8'($urandom_range(2, 20)), 8'($urandom_range(2, 255))};
    for (int p = 0; p < 6; p++) begin
      set_config(phase_slot[p], phase_max[p]);
      steady = (p % 3 == 2);
      goal = sent_items - ignored_items + RANDOM_ITEMS / 6;
      if (phase_max[p] == 8'hFF) send_random_frame(253, FLAW_NONE);
      while (sent_items - ignored_items < goal) begin
        maxp = int'(max_len_cfg) - 2;
        if (maxp < 0) plen = $urandom_range(0, 4);
        else if ($urandom_range(0, 79) == 0) plen = maxp;
        else plen = $urandom_range(0, maxp < 10 ? maxp : 10);
        case ($urandom_range(0, 19))
          12, 18:  flaw = FLAW_SUM;
          13:      flaw = FLAW_XOR;
          14:      flaw = FLAW_ESC;
          15, 19:  flaw = FLAW_RESTART;
          16:      flaw = FLAW_SLOT;
          17:      flaw = FLAW_LEN;
          default: flaw = FLAW_NONE;
        endcase
        if (flaw == FLAW_SLOT || flaw == FLAW_LEN) plen = $urandom_range(0, 2);
        send_random_frame(plen, flaw);
        // Line noise between frames is ignored by the idle receiver.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            noise = 8'($urandom);
            if (noise == HDR_BYTE) noise = 8'h00;
            send_byte(noise);
            ignored_items++;
          end
        end
      end
    end
  endtask

  initial begin
    error_count    = 0;
    mismatch_count = 0;
    sent_items     = 0;
    ignored_items  = 0;
    burst_left     = 0;
    steady         = 1'b0;
    quiet_cycles   = 0;
    slot_cfg       = SLOT_ID_RST;
    max_len_cfg    = MAX_LENGTH_RST;
    clear_frame();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_config();
    test_frame_faults();
    test_register_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += expected_results.size();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
